[rtl/gha_pkg.sv]
// Shared types and constants for the GHASH accumulator.
// Used by every module in rtl/; depends on nothing else.
`timescale 1ns / 1ps

package gha_pkg;

	localparam int HALF_W = 64;
	localparam int BLK_W = 128;
	localparam int COUNT_W = 5;
	localparam int BLK_BYTES = BLK_W / 8;
	localparam logic [COUNT_W-1:0] FULL_BYTES = COUNT_W'(BLK_BYTES);

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_KEY_HI = 1'b0,
		REG_KEY_LO = 1'b1
	} cfg_reg_t;

	// Padded block and its start flag, as held in the input stage.
	typedef struct packed {
		logic [BLK_W-1:0] data;
		logic start;
	} blk_t;

endpackage

[rtl/ghash_accumulator.sv]
// GHASH accumulator: absorbs one 128-bit block and multiplies it by H; one
// request per cycle while out_ready does not hold the digest back. A request
// is registered in the input stage, then its digest in the accumulator
// register; the single GF(2^128) multiply feeding it sets the cycle time.
// Reset clears the hash key, the accumulator and both valid flags.
// Depends on gha_pkg, gha_pad and gha_gfmul.
`timescale 1ns / 1ps

module ghash_accumulator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [0:0]                  cfg_index,
	input  logic [gha_pkg::HALF_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [gha_pkg::HALF_W-1:0]  block_hi,
	input  logic [gha_pkg::HALF_W-1:0]  block_lo,
	input  logic [gha_pkg::COUNT_W-1:0] byte_count,
	input  logic                        start_req,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gha_pkg::HALF_W-1:0]  digest_hi,
	output logic [gha_pkg::HALF_W-1:0]  digest_lo
);

	logic [gha_pkg::HALF_W-1:0] key_hi_q;
	logic [gha_pkg::HALF_W-1:0] key_lo_q;
	logic [gha_pkg::BLK_W-1:0]  acc_q;
	logic                       out_valid_q;
	gha_pkg::blk_t              blk_in;
	gha_pkg::blk_t              blk_s1;
	logic                       valid_s1;
	logic                       adv_s1;
	logic [gha_pkg::BLK_W-1:0]  mul_x;
	logic [gha_pkg::BLK_W-1:0]  mul_z;

	gha_pad u_pad (
		.block_hi   (block_hi),
		.block_lo   (block_lo),
		.byte_count (byte_count),
		.start_req  (start_req),
		.blk        (blk_in)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
		end else if (cfg_we) begin
			case (gha_pkg::cfg_reg_t'(cfg_index))
				gha_pkg::REG_KEY_HI: key_hi_q <= cfg_data;
				gha_pkg::REG_KEY_LO: key_lo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The input stage moves on whenever the digest register is free or taken.
	assign adv_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			blk_s1 <= blk_in;
		end
	end

	assign mul_x = (blk_s1.start ? '0 : acc_q) ^ blk_s1.data;

	gha_gfmul u_gfmul (
		.x (mul_x),
		.y ({key_hi_q, key_lo_q}),
		.z (mul_z)
	);

	// The accumulator doubles as the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				acc_q <= mul_z;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign digest_hi = acc_q[gha_pkg::BLK_W-1:gha_pkg::HALF_W];
	assign digest_lo = acc_q[gha_pkg::HALF_W-1:0];

	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid_q)
		else $error("input stage advanced without producing a digest");

	a_acc_only_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(acc_q))
		else $error("accumulator changed without an advancing request");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(blk_s1))
		else $error("stalled input stage lost or changed its request");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("empty input stage refused a request");

endmodule

[rtl/gha_pad.sv]
// Zero-pads a partial input block after its valid leading bytes.
// Depends on gha_pkg.
`timescale 1ns / 1ps

module gha_pad (
	input  logic [gha_pkg::HALF_W-1:0]  block_hi,
	input  logic [gha_pkg::HALF_W-1:0]  block_lo,
	input  logic [gha_pkg::COUNT_W-1:0] byte_count,
	input  logic                        start_req,
	output gha_pkg::blk_t               blk
);

	logic [gha_pkg::COUNT_W-1:0] n_sat;
	logic [gha_pkg::BLK_W-1:0] mask;

	// Counts above a full block saturate; a count of zero keeps nothing.
	assign n_sat = (byte_count > gha_pkg::FULL_BYTES) ? gha_pkg::FULL_BYTES : byte_count;

	always_comb begin
		mask = '0;
		for (int b = 0; b < gha_pkg::BLK_BYTES; b++) begin
			if (gha_pkg::COUNT_W'(b) < n_sat) begin
				mask[gha_pkg::BLK_W-1-8*b -: 8] = 8'hFF;
			end
		end
	end

	assign blk.data = {block_hi, block_lo} & mask;
	assign blk.start = start_req;

endmodule

[rtl/gha_gfmul.sv]
// Combinational GF(2^128) multiplier in GCM bit order.
// Carry-less product followed by a fixed two-fold reduction. Depends on gha_pkg.
`timescale 1ns / 1ps

module gha_gfmul (
	input  logic [gha_pkg::BLK_W-1:0] x,
	input  logic [gha_pkg::BLK_W-1:0] y,
	output logic [gha_pkg::BLK_W-1:0] z
);

	localparam int PROD_W = 2 * gha_pkg::BLK_W - 1;
	localparam int HIGH_W = PROD_W - gha_pkg::BLK_W;
	localparam int FOLD_W = gha_pkg::BLK_W + 7;

	// GCM numbers the first bit as the constant coefficient, so the
	// operands are reversed into ordinary polynomial order and back.
	function automatic logic [gha_pkg::BLK_W-1:0] bit_rev(input logic [gha_pkg::BLK_W-1:0] v);
		logic [gha_pkg::BLK_W-1:0] r;
		for (int i = 0; i < gha_pkg::BLK_W; i++) begin
			r[i] = v[gha_pkg::BLK_W-1-i];
		end
		return r;
	endfunction

	function automatic logic [PROD_W-1:0] clmul(input logic [gha_pkg::BLK_W-1:0] a,
			input logic [gha_pkg::BLK_W-1:0] b);
		logic [PROD_W-1:0] c;
		c = '0;
		for (int i = 0; i < gha_pkg::BLK_W; i++) begin
			c = c ^ (({{HIGH_W{1'b0}}, b} << i) & {PROD_W{a[i]}});
		end
		return c;
	endfunction

	// Reduction modulo x^128 + x^7 + x^2 + x + 1. The first fold leaves at
	// most seven bits above degree 127, which a second fold removes.
	function automatic logic [gha_pkg::BLK_W-1:0] gf_reduce(input logic [PROD_W-1:0] c);
		logic [HIGH_W-1:0] h;
		logic [FOLD_W-1:0] e;
		logic [6:0] g;
		h = c[PROD_W-1:gha_pkg::BLK_W];
		e = {7'b0, c[gha_pkg::BLK_W-1:0]} ^ {8'b0, h} ^ {7'b0, h, 1'b0}
			^ {6'b0, h, 2'b0} ^ {1'b0, h, 7'b0};
		g = e[FOLD_W-1:gha_pkg::BLK_W];
		return e[gha_pkg::BLK_W-1:0] ^ {121'b0, g} ^ {120'b0, g, 1'b0}
			^ {119'b0, g, 2'b0} ^ {114'b0, g, 7'b0};
	endfunction

	assign z = bit_rev(gf_reduce(clmul(bit_rev(x), bit_rev(y))));

endmodule

[sim/ghash_accumulator_tb.sv]
// Self-checking testbench for ghash_accumulator: directed and random GHASH requests,
// checked against an in-bench GF(2^128) predictor. Depends on gha_pkg and the RTL.
`timescale 1ns / 1ps

module ghash_accumulator_tb;

	localparam int HALF_W = gha_pkg::HALF_W;
	localparam int BLK_W = gha_pkg::BLK_W;
	localparam int COUNT_W = gha_pkg::COUNT_W;
	localparam int BLK_BYTES = gha_pkg::BLK_BYTES;
	localparam logic [COUNT_W-1:0] FULL_BYTES = gha_pkg::FULL_BYTES;
	localparam int STALL_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 120;
	localparam logic [BLK_W-1:0] GCM_POLY = {8'hE1, 120'h0};
	localparam logic [BLK_W-1:0] GCM_ONE = {1'b1, 127'h0};

	typedef struct {
		logic [HALF_W-1:0] hi;
		logic [HALF_W-1:0] lo;
		logic [COUNT_W-1:0] count;
		logic start;
	} absorb_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = gha_pkg::REG_KEY_HI;
	logic [HALF_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [HALF_W-1:0] block_hi = '0;
	logic [HALF_W-1:0] block_lo = '0;
	logic [COUNT_W-1:0] byte_count = FULL_BYTES;
	logic start_req = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [HALF_W-1:0] digest_hi;
	logic [HALF_W-1:0] digest_lo;

	absorb_req_t absorb_q[$];
	logic [BLK_W-1:0] digest_q[$];
	logic [BLK_W-1:0] hash_key = '0;
	logic [BLK_W-1:0] ghash_acc = '0;
	int send_wait = 0;
	int recv_wait = 0;
	bit send_calm = 1'b0;
	bit recv_calm = 1'b0;
	int n_errors = 0;
	int n_results = 0;
	int idle_cycles = 0;

	ghash_accumulator u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.block_hi(block_hi),
		.block_lo(block_lo),
		.byte_count(byte_count),
		.start_req(start_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.digest_hi(digest_hi),
		.digest_lo(digest_lo)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic post_block(input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo,
			input logic [COUNT_W-1:0] count, input logic start);
		absorb_req_t req;
		req.hi = hi;
		req.lo = lo;
		req.count = count;
		req.start = start;
		absorb_q.push_back(req);
	endtask

	// Returns once every queued request has been accepted and its digest checked.
	task automatic wait_drained();
		do @(negedge clk); while (absorb_q.size() != 0 || in_valid || digest_q.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_hash_key(input logic [BLK_W-1:0] key);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= gha_pkg::REG_KEY_HI;
		cfg_data <= key[BLK_W-1:HALF_W];
		@(posedge clk);
		cfg_index <= gha_pkg::REG_KEY_LO;
		cfg_data <= key[HALF_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		hash_key = key;
	endtask

	// Driver: predicts the digest of each accepted request, then offers the next one.
	always @(posedge clk) begin : driver
		logic [BLK_W-1:0] blk, x, z, v;
		int n, i;
		bit free;
		absorb_req_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			free = !in_valid;
			if (in_valid && in_ready) begin
				free = 1'b1;
				// Counts above a full block saturate; bytes past the count read as zero.
				n = (byte_count > FULL_BYTES) ? BLK_BYTES : int'(byte_count);
				blk = {block_hi, block_lo} & ~({BLK_W{1'b1}} >> (8 * n));
				if (start_req)
					ghash_acc = '0;
				x = ghash_acc ^ blk;
				z = '0;
				v = hash_key;
				for (i = 0; i < BLK_W; i++) begin
					if (x[BLK_W-1-i])
						z ^= v;
					v = v[0] ? ((v >> 1) ^ GCM_POLY) : (v >> 1);
				end
				ghash_acc = z;
				digest_q.push_back(z);
			end
			if (free) begin
				if (send_wait > 0) begin
					send_wait--;
					in_valid <= 1'b0;
				end else if (absorb_q.size() > 0) begin
					req = absorb_q.pop_front();
					block_hi <= req.hi;
					block_lo <= req.lo;
					byte_count <= req.count;
					start_req <= req.start;
					in_valid <= 1'b1;
					if ($urandom_range(0, 15) == 0)
						send_calm = !send_calm;
					send_wait = send_calm ? 0 : $urandom_range(0, 11);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each digest against the oldest prediction and paces out_ready.
	always @(posedge clk) begin : monitor
		logic [BLK_W-1:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (digest_q.size() == 0) begin
					$error("digest %h_%h returned with no request pending", digest_hi, digest_lo);
					n_errors++;
				end else begin
					want = digest_q.pop_front();
					if (digest_hi !== want[BLK_W-1:HALF_W]) begin
						$error("digest_hi: expected %h, actual %h", want[BLK_W-1:HALF_W], digest_hi);
						n_errors++;
					end
					if (digest_lo !== want[HALF_W-1:0]) begin
						$error("digest_lo: expected %h, actual %h", want[HALF_W-1:0], digest_lo);
						n_errors++;
					end
				end
				n_results++;
				// A long hold-off lets the pipeline fill so that in_ready has to drop.
				if (n_results == 60 || n_results == 400) begin
					recv_wait = 300;
				end else begin
					if ($urandom_range(0, 15) == 0)
						recv_calm = !recv_calm;
					recv_wait = recv_calm ? 0 : $urandom_range(0, 11);
				end
			end else if (recv_wait > 0) begin
				recv_wait--;
			end
			out_ready <= (recv_wait == 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (idle_cycles >= STALL_LIMIT);
		$display("ghash_accumulator_tb failed");
		$finish;
	end

	initial begin : stimulus
		int phase, items, nblk, j;
		logic [BLK_W-1:0] key;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// The key is still zero from reset, so every digest is zero.
		post_block('1, '1, FULL_BYTES, 1'b1);
		post_block({$urandom, $urandom}, {$urandom, $urandom}, FULL_BYTES, 1'b0);
		wait_drained();

		write_hash_key({$urandom, $urandom, $urandom, $urandom});
		post_block('1, '1, FULL_BYTES, 1'b1);
		post_block('0, '0, FULL_BYTES, 1'b0);
		// A zero byte count absorbs an all-zero block but still multiplies by H.
		post_block('1, '1, 5'd0, 1'b0);
		post_block('1, '1, 5'd1, 1'b0);
		post_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd7, 1'b0);
		post_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd8, 1'b0);
		post_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd9, 1'b0);
		post_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd15, 1'b0);
		// Counts past a full block behave like a full block.
		post_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd17, 1'b0);
		post_block('1, '1, 5'd31, 1'b0);
		post_block({$urandom, $urandom}, {$urandom, $urandom}, FULL_BYTES, 1'b1);
		post_block({32'h0, $urandom}, {32'h0, $urandom}, FULL_BYTES, 1'b0);
		wait_drained();

		write_hash_key('1);
		post_block('1, '0, FULL_BYTES, 1'b1);
		post_block('0, '1, 5'd12, 1'b0);
		wait_drained();

		// The field's multiplicative identity turns the multiply into a plain XOR.
		write_hash_key(GCM_ONE);
		post_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd5, 1'b1);
		post_block({$urandom, $urandom}, {$urandom, $urandom}, FULL_BYTES, 1'b0);
		wait_drained();

		write_hash_key('0);
		post_block('1, '1, FULL_BYTES, 1'b0);
		post_block({$urandom, $urandom}, {$urandom, $urandom}, 5'd3, 1'b1);
		wait_drained();

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				1: key = '1;
				2: key = GCM_ONE;
				4: key = GCM_ONE >> $urandom_range(0, BLK_W - 1);
				default: key = {$urandom, $urandom, $urandom, $urandom};
			endcase
			write_hash_key(key);
			items = 0;
			while (items < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 6) == 0) begin
					post_block({$urandom, $urandom}, {$urandom, $urandom},
						COUNT_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
					items++;
				end else begin
					// A message: full blocks, a possibly partial tail, then the length block.
					nblk = $urandom_range(1, 6);
					for (j = 0; j < nblk; j++)
						post_block({$urandom, $urandom}, {$urandom, $urandom},
							(j == nblk - 1) ? COUNT_W'($urandom_range(1, BLK_BYTES)) : FULL_BYTES,
							j == 0);
					post_block({32'h0, $urandom}, {32'h0, $urandom}, FULL_BYTES, 1'b0);
					items += nblk + 1;
				end
			end
			wait_drained();
		end

		repeat (5) @(posedge clk);
		if (n_errors == 0 && digest_q.size() == 0)
			$display("ghash_accumulator_tb passed");
		else
			$display("ghash_accumulator_tb failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/gha_pkg.sv
rtl/gha_pad.sv
rtl/gha_gfmul.sv
rtl/ghash_accumulator.sv
sim/ghash_accumulator_tb.sv
